// ----- sv/apfr_pkg.sv -----
`timescale 1ns / 1ps

package apfr_pkg;

  localparam int unsigned MAX_DATA_BYTES = 64;

  localparam logic [7:0] START_BYTE     = 8'h7E;
  localparam logic [7:0] TYPE_RX_PACKET = 8'h90;
  localparam logic [7:0] TYPE_TX_STATUS = 8'h8B;

  localparam int unsigned RX_HEADER_BYTES = 12;
  localparam int unsigned TX_MIN_BYTES    = 7;
  localparam int unsigned ADDR_BYTES      = 8;

  localparam int unsigned OFS_TYPE      = 0;
  localparam int unsigned OFS_FRAME_ID  = 1;
  localparam int unsigned OFS_RETRY     = 4;
  localparam int unsigned OFS_DELIVERY  = 5;
  localparam int unsigned OFS_DISCOVERY = 6;
  localparam int unsigned OFS_OPTIONS   = 11;

  localparam logic KIND_RX_PACKET = 1'b0;
  localparam logic KIND_TX_STATUS = 1'b1;

endpackage

// ----- sv/apfr_ram.sv -----
`timescale 1ns / 1ps

module apfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/api_frame_receive_parser.sv -----
`timescale 1ns / 1ps
// After the checksum byte, a status result or an empty receive packet passes through
// ST_SINGLE to the output registers; each payload result through ST_READ, then ST_LOAD.
// Throughput: one byte per cycle while parsing; a receive packet then emits its results
// in turn (buffer read, then output load once output is free); rx input is held off.
// Reset: parser returns to start-byte hunt, output empties; buffer is not cleared.
module api_frame_receive_parser #(
  parameter int unsigned MAX_DATA_BYTES = apfr_pkg::MAX_DATA_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_kind,
  output logic [63:0] source_address,
  output logic [7:0]  receive_options,
  output logic [5:0]  payload_length,
  output logic [7:0]  payload_byte,
  output logic        payload_present,
  output logic [7:0]  status_frame_id,
  output logic [7:0]  delivery_status,
  output logic [7:0]  retry_count,
  output logic [7:0]  discovery_status,
  output logic        last_of_frame
);

  localparam int unsigned AW = $clog2(MAX_DATA_BYTES);
  localparam int unsigned CW = $clog2(MAX_DATA_BYTES + 1);

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_DATA,
    ST_CHECK,
    ST_READ,
    ST_LOAD,
    ST_SINGLE
  } state_t;

  state_t         state;
  logic [7:0]     len_hi;
  logic [CW-1:0]  exp_len;
  logic [CW-1:0]  rcv_count;
  logic [7:0]     run_sum;
  logic [7:0]     type_byte;
  logic [63:0]    addr_reg;
  logic [7:0]     opts_reg;
  logic [7:0]     fid_reg;
  logic [7:0]     retry_reg;
  logic [7:0]     deliv_reg;
  logic [7:0]     disc_reg;
  logic           single_status;
  logic [CW-1:0]  emit_idx;

  logic           in_fire;
  logic           out_free;
  logic           out_load;
  logic [15:0]    full_len;
  logic [CW-1:0]  rcv_count_next;
  logic [CW-1:0]  plen;
  logic           emit_last;
  logic           sum_ok;
  logic           rx_ok;
  logic           tx_ok;
  logic           ram_we;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  assign in_ready       = (state == ST_WAIT) || (state == ST_LEN_HI) || (state == ST_LEN_LO)
                          || (state == ST_DATA) || (state == ST_CHECK);
  assign in_fire        = in_valid && in_ready;
  assign out_free       = !out_valid || out_ready;
  assign out_load       = ((state == ST_LOAD) || (state == ST_SINGLE)) && out_free;
  assign full_len       = {len_hi, rx_byte};
  assign rcv_count_next = rcv_count + CW'(1);
  assign plen           = exp_len - CW'(apfr_pkg::RX_HEADER_BYTES);
  assign emit_last      = (emit_idx + CW'(1)) == plen;
  assign sum_ok         = (run_sum + rx_byte) == 8'hFF;
  assign rx_ok          = (type_byte == apfr_pkg::TYPE_RX_PACKET)
                          && (exp_len >= CW'(apfr_pkg::RX_HEADER_BYTES));
  assign tx_ok          = (type_byte == apfr_pkg::TYPE_TX_STATUS)
                          && (exp_len >= CW'(apfr_pkg::TX_MIN_BYTES));

  assign ram_we    = in_fire && (state == ST_DATA);
  assign ram_re    = (state == ST_READ);
  assign ram_raddr = AW'(emit_idx + CW'(apfr_pkg::RX_HEADER_BYTES));

  apfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_DATA_BYTES)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(rcv_count[AW-1:0]),
    .wdata(rx_byte),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT;
      out_valid <= 1'b0;
      rcv_count <= '0;
      run_sum   <= '0;
      exp_len   <= '0;
      emit_idx  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_WAIT: begin
          if (in_fire && rx_byte == apfr_pkg::START_BYTE) begin
            state <= ST_LEN_HI;
          end
        end
        ST_LEN_HI: begin
          if (in_fire) begin
            len_hi <= rx_byte;
            state  <= ST_LEN_LO;
          end
        end
        ST_LEN_LO: begin
          if (in_fire) begin
            if (full_len == 16'd0 || full_len > 16'(MAX_DATA_BYTES)) begin
              state <= ST_WAIT;
            end else begin
              exp_len   <= CW'(full_len);
              rcv_count <= '0;
              run_sum   <= '0;
              state     <= ST_DATA;
            end
          end
        end
        ST_DATA: begin
          if (in_fire) begin
            run_sum   <= run_sum + rx_byte;
            rcv_count <= rcv_count_next;
            if (rcv_count == CW'(apfr_pkg::OFS_TYPE)) begin
              type_byte <= rx_byte;
            end
            if (rcv_count >= CW'(1) && rcv_count <= CW'(apfr_pkg::ADDR_BYTES)) begin
              addr_reg <= {addr_reg[55:0], rx_byte};
            end
            if (rcv_count == CW'(apfr_pkg::OFS_FRAME_ID)) begin
              fid_reg <= rx_byte;
            end
            if (rcv_count == CW'(apfr_pkg::OFS_RETRY)) begin
              retry_reg <= rx_byte;
            end
            if (rcv_count == CW'(apfr_pkg::OFS_DELIVERY)) begin
              deliv_reg <= rx_byte;
            end
            if (rcv_count == CW'(apfr_pkg::OFS_DISCOVERY)) begin
              disc_reg <= rx_byte;
            end
            if (rcv_count == CW'(apfr_pkg::OFS_OPTIONS)) begin
              opts_reg <= rx_byte;
            end
            if (rcv_count_next >= exp_len) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (in_fire) begin
            if (sum_ok && rx_ok) begin
              single_status <= apfr_pkg::KIND_RX_PACKET;
              emit_idx      <= '0;
              state         <= (plen == '0) ? ST_SINGLE : ST_READ;
            end else if (sum_ok && tx_ok) begin
              single_status <= apfr_pkg::KIND_TX_STATUS;
              state         <= ST_SINGLE;
            end else begin
              state <= ST_WAIT;
            end
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            frame_kind       <= apfr_pkg::KIND_RX_PACKET;
            source_address   <= addr_reg;
            receive_options  <= opts_reg;
            payload_length   <= 6'(plen);
            payload_byte     <= ram_rdata;
            payload_present  <= 1'b1;
            status_frame_id  <= '0;
            delivery_status  <= '0;
            retry_count      <= '0;
            discovery_status <= '0;
            last_of_frame    <= emit_last;
            emit_idx         <= emit_idx + CW'(1);
            state            <= emit_last ? ST_WAIT : ST_READ;
          end
        end
        ST_SINGLE: begin
          if (out_free) begin
            frame_kind      <= single_status;
            payload_length  <= '0;
            payload_byte    <= '0;
            payload_present <= 1'b0;
            last_of_frame   <= 1'b1;
            if (single_status == apfr_pkg::KIND_TX_STATUS) begin
              source_address   <= '0;
              receive_options  <= '0;
              status_frame_id  <= fid_reg;
              delivery_status  <= deliv_reg;
              retry_count      <= retry_reg;
              discovery_status <= disc_reg;
            end else begin
              source_address   <= addr_reg;
              receive_options  <= opts_reg;
              status_frame_id  <= '0;
              delivery_status  <= '0;
              retry_count      <= '0;
              discovery_status <= '0;
            end
            state <= ST_WAIT;
          end
        end
        default: begin
          state <= ST_WAIT;
        end
      endcase
    end
  end

endmodule
